@@ hdl/lmfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfr_pkg: shared types and constants for the LED matrix frame receiver
// Item structs, sizing constants, control codes and the display patterns.
// ----------------------------------------------------------------------------
package lmfr_pkg;

   localparam int ROWS         = 8;
   localparam int WINDOW_BYTES = 11;
   localparam int COLS         = 8;
   localparam int SELECT_LINES = 8;
   localparam int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 8;

   localparam logic [7:0] SYNC_BYTE    = 8'hA5;
   localparam logic [7:0] PATTERN_EVEN = 8'hAA;
   localparam logic [7:0] PATTERN_ODD  = 8'h55;
   localparam logic [7:0] OWN_ID_RESET       = 8'h00;
   localparam logic [7:0] BROADCAST_ID_RESET = 8'hFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OWN_ID       = 1'b0,
      CSR_BROADCAST_ID = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic       rx_valid;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [COLS-1:0]         column_drive_n;
      logic [SELECT_LINES-1:0] row_select;
      logic                    frame_loaded;
   } rsp_type;

endpackage

@@ hdl/led_matrix_frame_receiver_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_frame_receiver_scan: LED matrix row scan with framed serial load
// An accepted item's result is registered in the output register, or in the
// skid register while the output is held. Throughput: one item per cycle,
// sustained, while results are taken; the skid holds one stalled result.
// Reset is synchronous and active high: it empties the output stages, clears
// the byte window and row counter, and loads the alternating test pattern.
// ----------------------------------------------------------------------------
module led_matrix_frame_receiver_scan (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  lmfr_pkg::req_type                      req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output lmfr_pkg::rsp_type                      rsp_payload,
   input  logic                                   csr_we,
   input  logic [lmfr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [lmfr_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import lmfr_pkg::*;

   // Configuration registers.
   logic [7:0] own_id_ff;
   logic [7:0] broadcast_id_ff;

   // The byte window is kept as a shift line: entry 0 is the oldest byte and
   // the newest byte enters at the top. This gives the same view as a ring
   // buffer with a pointer to the oldest entry, without any address logic.
   logic [7:0] window_ff [WINDOW_BYTES];
   logic [7:0] window_in [WINDOW_BYTES];

   logic [COLS-1:0]  frame_ff [ROWS];
   logic [ROW_W-1:0] row_counter_ff;
   logic [ROW_W-1:0] row_counter_in;

   // Output register and skid register.
   rsp_type rsp_ff;
   rsp_type skid_ff;
   logic    rsp_valid_ff;
   logic    skid_valid_ff;

   logic    req_accept;
   logic    rsp_take;
   logic    frame_match;
   rsp_type result;

   // The skid register is the only place a second result can wait, so the
   // input stalls exactly while it is occupied. This is a registered signal.
   assign req_stall   = skid_valid_ff;
   assign req_accept  = req_valid && !skid_valid_ff;
   assign rsp_take    = rsp_valid_ff && !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Window as it stands after this item's byte, if any, has been shifted in.
   always_comb begin
      for (int k = 0; k < WINDOW_BYTES; k++) begin
         window_in[k] = window_ff[k];
      end
      if (req_payload.rx_valid) begin
         for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
            window_in[k] = window_ff[k + 1];
         end
         window_in[WINDOW_BYTES-1] = req_payload.rx_byte;
      end
   end

   // A frame is taken when a byte completes a window that starts with the
   // sync byte followed by our own address or the broadcast address.
   assign frame_match = req_payload.rx_valid
                        && (window_in[0] == SYNC_BYTE)
                        && ((window_in[1] == own_id_ff)
                            || (window_in[1] == broadcast_id_ff));

   assign row_counter_in = (row_counter_ff == ROW_W'(ROWS - 1))
                           ? '0 : row_counter_ff + ROW_W'(1);

   // The row is driven from the frame before any load by the same item.
   always_comb begin
      result.column_drive_n = ~frame_ff[row_counter_ff];
      for (int b = 0; b < SELECT_LINES; b++) begin
         result.row_select[b] = (b < ROWS) && (row_counter_ff == ROW_W'(b));
      end
      result.frame_loaded = frame_match;
   end

   // Configuration writes. An index past the register list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff       <= OWN_ID_RESET;
         broadcast_id_ff <= BROADCAST_ID_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OWN_ID:       own_id_ff       <= csr_wdata[7:0];
            CSR_BROADCAST_ID: broadcast_id_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Block state: window, frame rows and the row counter move per item.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW_BYTES; k++) begin
            window_ff[k] <= '0;
         end
         for (int r = 0; r < ROWS; r++) begin
            frame_ff[r] <= (r % 2 == 1) ? PATTERN_ODD : PATTERN_EVEN;
         end
         row_counter_ff <= '0;
      end else if (req_accept) begin
         row_counter_ff <= row_counter_in;
         for (int k = 0; k < WINDOW_BYTES; k++) begin
            window_ff[k] <= window_in[k];
         end
         // Rows with no window byte behind them keep their contents.
         if (frame_match) begin
            for (int r = 0; r < ROWS; r++) begin
               if (r + 2 < WINDOW_BYTES) begin
                  frame_ff[r] <= window_in[r + 2];
               end
            end
         end
      end
   end

   // Output side. When the output register frees up, a waiting skid result
   // moves up first so that results leave in order.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_ff        <= skid_ff;
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= req_accept;
            if (req_accept) begin
               rsp_ff <= result;
            end
         end
      end else if (req_accept) begin
         skid_ff       <= result;
         skid_valid_ff <= 1'b1;
      end
   end

   // A result in the skid register always has an older one ahead of it.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a result while the output is empty");

   // An item taken while the output is held must land in the skid register.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && req_accept) |=> skid_valid_ff)
      else $error("item accepted under output stall was not kept");

   // Every delivered result selects exactly one row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot(rsp_ff.row_select))
      else $error("row select is not one-hot");

   // The row counter steps by one row, with wrap, for each accepted item.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (row_counter_ff == $past(row_counter_in)))
      else $error("row counter did not advance on an accepted item");

   // A frame load can only come from an item that carried a byte.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_payload.rx_valid) |-> !result.frame_loaded)
      else $error("frame loaded by an item without a serial byte");

endmodule
